FILE: rtl/core/lsq_pkg.sv
// Shared types and constants for the largest-square finder.
// No dependencies; used by every module in rtl/core.
package lsq_pkg;
  localparam int MAX_DIM_DEF = 128;

  localparam logic [1:0] CFG_ROWS  = 2'd0;
  localparam logic [1:0] CFG_COLS  = 2'd1;
  localparam logic [1:0] CFG_LIMIT = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_BUILD,
    ST_SRCH_INIT,
    ST_SCAN,
    ST_SRCH_STEP,
    ST_FINAL_INIT,
    ST_FINAL_SCAN,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_start;   // begin clear sweep of hole map
    logic bld_start;   // begin prefix build
    logic srch_init;   // load lo/hi
    logic scan_start;  // start scan at mid (or side when final)
    logic final_sel;   // scan at best side instead of mid
    logic srch_step;   // apply scan result to lo/hi
    logic emit;        // drive the result word
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic bld_done;
    logic scan_done;
    logic srch_over;   // lo > hi, or hi is zero
    logic side_zero;
  } stat_t;
endpackage

FILE: rtl/core/lsq_ctrl.sv
// Sequencer for the largest-square finder.
// Depends on lsq_pkg.
module lsq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           solve_req,
  input  lsq_pkg::stat_t stat,
  output lsq_pkg::cmd_t  cmd,
  output logic           busy
);
  lsq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= lsq_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    case (state_r)
      lsq_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (solve_req) begin
          cmd.bld_start = 1'b1;
          state_nxt = lsq_pkg::ST_BUILD;
        end
      end
      lsq_pkg::ST_BUILD: begin
        if (stat.bld_done) state_nxt = lsq_pkg::ST_SRCH_INIT;
      end
      lsq_pkg::ST_SRCH_INIT: begin
        cmd.srch_init = 1'b1;
        state_nxt = lsq_pkg::ST_SRCH_STEP;
      end
      lsq_pkg::ST_SRCH_STEP: begin
        if (stat.srch_over) begin
          state_nxt = lsq_pkg::ST_FINAL_INIT;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt = lsq_pkg::ST_SCAN;
        end
      end
      lsq_pkg::ST_SCAN: begin
        if (stat.scan_done) begin
          cmd.srch_step = 1'b1;
          state_nxt = lsq_pkg::ST_SRCH_STEP;
        end
      end
      lsq_pkg::ST_FINAL_INIT: begin
        if (stat.side_zero) begin
          state_nxt = lsq_pkg::ST_EMIT;
        end else begin
          cmd.scan_start = 1'b1;
          cmd.final_sel = 1'b1;
          state_nxt = lsq_pkg::ST_FINAL_SCAN;
        end
      end
      lsq_pkg::ST_FINAL_SCAN: begin
        cmd.final_sel = 1'b1;
        if (stat.scan_done) state_nxt = lsq_pkg::ST_EMIT;
      end
      lsq_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
        cmd.clr_start = 1'b1;
        state_nxt = lsq_pkg::ST_CLEAR;
      end
      lsq_pkg::ST_CLEAR: begin
        if (stat.clr_done) state_nxt = lsq_pkg::ST_IDLE;
      end
      default: state_nxt = lsq_pkg::ST_IDLE;
    endcase
  end
endmodule

FILE: rtl/core/lsq_dpath.sv
// Datapath: hole map, prefix table, build / scan / search registers.
// Depends on lsq_pkg; driven by lsq_ctrl.
module lsq_dpath #(
  parameter int MAX_DIM = lsq_pkg::MAX_DIM_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           hole_we,
  input  logic [7:0]     hole_row,
  input  logic [7:0]     hole_col,
  input  logic [7:0]     row_count,
  input  logic [7:0]     col_count,
  input  logic [3:0]     hole_limit,
  input  lsq_pkg::cmd_t  cmd,
  output lsq_pkg::stat_t stat,
  output logic           out_valid,
  output logic [7:0]     out_bottom_x,
  output logic [7:0]     out_bottom_y,
  output logic [7:0]     out_top_x,
  output logic [7:0]     out_top_y,
  output logic [7:0]     out_square_side,
  output logic [3:0]     out_holes_inside
);
  localparam int DW = $clog2(MAX_DIM + 1);        // holds 0..MAX_DIM
  localparam int MD = MAX_DIM * MAX_DIM;
  localparam int MW = (MD > 1) ? $clog2(MD) : 1;
  localparam int PS = MAX_DIM + 1;
  localparam int PD = PS * PS;
  localparam int PA = $clog2(PD);
  localparam int SW = $clog2(MD + 1);             // prefix sum width
  localparam logic [DW-1:0] DMAX = DW'(MAX_DIM);

  // ---------------- hole map: one write port, one registered read
  logic          hmap_m [MD];
  logic          hmap_q_r;
  logic [MW-1:0] hmap_wa;
  logic          hmap_wd, hmap_wen;
  logic [MW-1:0] hmap_ra;

  always_ff @(posedge clk) begin
    if (hmap_wen) hmap_m[hmap_wa] <= hmap_wd;
    hmap_q_r <= hmap_m[hmap_ra];
  end

  // clear sweep; runs after reset too (the map itself has no reset)
  logic          clr_act_r;
  logic [MW-1:0] clr_idx_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_act_r <= 1'b1;
      clr_idx_r <= '0;
    end else if (cmd.clr_start) begin
      clr_act_r <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_act_r) begin
      if (clr_idx_r == MW'(MD - 1)) clr_act_r <= 1'b0;
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end
  assign stat.clr_done = !clr_act_r;

  logic hr_ok, hc_ok;
  assign hr_ok = (hole_row != 8'd0) && ({24'd0, hole_row} <= 32'(MAX_DIM));
  assign hc_ok = (hole_col != 8'd0) && ({24'd0, hole_col} <= 32'(MAX_DIM));

  always_comb begin
    hmap_wen = 1'b0;
    hmap_wa  = '0;
    hmap_wd  = 1'b0;
    if (clr_act_r) begin
      hmap_wen = 1'b1;
      hmap_wa  = clr_idx_r;
    end else if (hole_we && hr_ok && hc_ok) begin
      hmap_wen = 1'b1;
      hmap_wd  = 1'b1;
      hmap_wa  = MW'((32'(hole_row) - 32'd1) * 32'(MAX_DIM) + 32'(hole_col) - 32'd1);
    end
  end

  // ---------------- effective sizes
  logic [DW-1:0] rows, cols, mindim;
  assign rows = ({24'd0, row_count} > 32'(MAX_DIM)) ? DMAX : DW'(row_count);
  assign cols = ({24'd0, col_count} > 32'(MAX_DIM)) ? DMAX : DW'(col_count);
  assign mindim = (rows < cols) ? rows : cols;

  // ---------------- prefix table: one write, one registered read
  logic [SW-1:0] ptab_m [PD];
  logic [SW-1:0] ptab_q_r;
  logic [PA-1:0] ptab_ra, ptab_wa;
  logic [SW-1:0] ptab_wd;
  logic          ptab_wen;

  always_ff @(posedge clk) begin
    if (ptab_wen) ptab_m[ptab_wa] <= ptab_wd;
    ptab_q_r <= ptab_m[ptab_ra];
  end

  // Build walks row by row. For cell (r,c), r,c>=1:
  //   P[r][c] = P[r-1][c] + rowsum(r, 1..c)
  // Per cell: phase 0 issue read of P[r-1][c] and map; phase 1 write.
  logic          bld_act_r, bld_ph_r;
  logic [DW-1:0] br_r, bc_r;
  logic [SW-1:0] rsum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bld_act_r <= 1'b0;
      bld_ph_r  <= 1'b0;
    end else if (cmd.bld_start) begin
      bld_act_r <= 1'b1;
      bld_ph_r  <= 1'b0;
      br_r      <= '0;
      bc_r      <= '0;
      rsum_r    <= '0;
    end else if (bld_act_r) begin
      if (!bld_ph_r) begin
        bld_ph_r <= 1'b1;
      end else begin
        bld_ph_r <= 1'b0;
        if (bc_r == cols) begin
          bc_r   <= '0;
          rsum_r <= '0;
          if (br_r == rows) bld_act_r <= 1'b0;
          br_r <= br_r + 1'b1;
        end else begin
          bc_r <= bc_r + 1'b1;
          if (br_r != '0 && bc_r != '0) rsum_r <= rsum_r + SW'(hmap_q_r);
        end
      end
    end
  end
  assign stat.bld_done = !bld_act_r && !cmd.bld_start;

  logic bld_wen;
  assign bld_wen = bld_act_r && bld_ph_r;

  // ---------------- search registers
  logic [DW-1:0] lo_r, hi_r, mid, side_r, s_cur;
  logic [DW:0]   losum;
  assign losum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid   = losum[DW:1];
  assign stat.srch_over = ({1'b0, lo_r} > {1'b0, hi_r}) || (hi_r == '0);
  assign stat.side_zero = (side_r == '0);

  // ---------------- scan: per window four reads, then combine
  logic          scn_act_r;
  logic [2:0]    scn_ph_r;
  logic [DW-1:0] sr_r, sc_r, sz_r;
  logic [SW-1:0] pa_r, pb_r, pd_r;
  logic [SW-1:0] best_r;
  logic          best_v_r;
  logic [DW-1:0] bstr_r, bstc_r;
  logic [SW-1:0] wsum;
  logic [SW-1:0] win_best;
  logic          last_win;

  assign s_cur = cmd.final_sel ? side_r : mid;
  assign wsum  = pa_r - pb_r - pd_r + ptab_q_r;
  // fewest holes of the probe, counting the window that closes it
  assign win_best = (!best_v_r || wsum < best_r) ? wsum : best_r;
  assign last_win = (32'(sr_r) + 32'(sz_r) == 32'(rows)) &&
                    (32'(sc_r) + 32'(sz_r) == 32'(cols));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scn_act_r <= 1'b0;
      scn_ph_r  <= '0;
    end else if (cmd.scan_start) begin
      scn_act_r <= 1'b1;
      scn_ph_r  <= '0;
      sr_r      <= '0;
      sc_r      <= '0;
      sz_r      <= s_cur;
      best_v_r  <= 1'b0;
      bstr_r    <= '0;
      bstc_r    <= '0;
    end else if (scn_act_r) begin
      case (scn_ph_r)
        3'd0: scn_ph_r <= 3'd1;
        3'd1: begin
          pa_r     <= ptab_q_r;
          scn_ph_r <= 3'd2;
        end
        3'd2: begin
          pb_r     <= ptab_q_r;
          scn_ph_r <= 3'd3;
        end
        3'd3: begin
          pd_r     <= ptab_q_r;
          scn_ph_r <= 3'd4;
        end
        3'd4: begin
          scn_ph_r <= '0;
          if (!best_v_r || wsum < best_r) begin
            best_v_r <= 1'b1;
            best_r   <= wsum;
            bstr_r   <= sr_r;
            bstc_r   <= sc_r;
          end
          if (last_win) begin
            scn_act_r <= 1'b0;
          end else if (32'(sc_r) + 32'(sz_r) == 32'(cols)) begin
            sc_r <= '0;
            sr_r <= sr_r + 1'b1;
          end else begin
            sc_r <= sc_r + 1'b1;
          end
        end
        default: scn_ph_r <= '0;
      endcase
    end
  end
  assign stat.scan_done = scn_act_r && (scn_ph_r == 3'd4) && last_win;

  // scan read address per phase: a, b, d, e corners
  logic [DW-1:0] rd_r, rd_c;
  always_comb begin
    rd_r = sr_r;
    rd_c = sc_r;
    case (scn_ph_r)
      3'd0: begin rd_r = sr_r + sz_r; rd_c = sc_r + sz_r; end
      3'd1: begin rd_r = sr_r + sz_r; rd_c = sc_r;        end
      3'd2: begin rd_r = sr_r;        rd_c = sc_r + sz_r; end
      default: ;
    endcase
  end

  always_comb begin
    ptab_wen = bld_wen;
    ptab_wa  = PA'(32'(br_r) * 32'(PS) + 32'(bc_r));
    ptab_wd  = '0;
    if (br_r != '0 && bc_r != '0)
      ptab_wd = ptab_q_r + rsum_r + SW'(hmap_q_r);
    if (bld_act_r)
      ptab_ra = PA'((32'(br_r) - 32'd1) * 32'(PS) + 32'(bc_r));
    else
      ptab_ra = PA'(32'(rd_r) * 32'(PS) + 32'(rd_c));
    hmap_ra = MW'((32'(br_r) - 32'd1) * 32'(MAX_DIM) + 32'(bc_r) - 32'd1);
  end

  always_ff @(posedge clk) begin
    if (cmd.srch_init) begin
      lo_r   <= DW'(1);
      hi_r   <= mindim;
      side_r <= '0;
    end else if (cmd.srch_step) begin
      if (win_best <= SW'(hole_limit)) begin
        side_r <= mid;
        lo_r   <= mid + 1'b1;
      end else begin
        hi_r <= mid - 1'b1;
      end
    end
  end

  // result register
  logic       ov_r;
  logic [7:0] obx_r, oby_r, otx_r, oty_r, os_r;
  logic [3:0] oh_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= cmd.emit;
    if (cmd.emit) begin
      if (side_r == '0) begin
        {obx_r, oby_r, otx_r, oty_r, os_r, oh_r} <= '0;
      end else begin
        obx_r <= 8'(32'(bstr_r) + 32'(side_r));
        oby_r <= 8'(32'(bstc_r) + 32'd1);
        otx_r <= 8'(32'(bstr_r) + 32'd1);
        oty_r <= 8'(32'(bstc_r) + 32'(side_r));
        os_r  <= 8'(side_r);
        oh_r  <= best_r[3:0];
      end
    end
  end
  assign out_valid        = ov_r;
  assign out_bottom_x     = obx_r;
  assign out_bottom_y     = oby_r;
  assign out_top_x        = otx_r;
  assign out_top_y        = oty_r;
  assign out_square_side  = os_r;
  assign out_holes_inside = oh_r;
endmodule

FILE: rtl/core/largest_square_few_holes_finder_top.sv
// Top level of the largest-square finder: config registers, controller, datapath.
// Depends on lsq_pkg, lsq_ctrl and lsq_dpath.
//
// Usage: pulse start with in_req_type=0 to mark a hole at (in_hole_row,
// in_hole_col), 1-based; holes outside 1..MAX_DIM are dropped. A hole word is
// written as it is taken, so holes may arrive back to back while busy is low.
// A word with in_req_type=1 solves: build the prefix table over the grid in
// use, binary-search the side, rescan the winning side, then emit one result
// with out_valid high for exactly one cycle. The receiver cannot stall; take
// the result in that cycle. After the result, the hole map is swept clear,
// one cell a cycle, with busy held high. Reset starts that same clearing
// sweep, so busy stays high after reset until it ends; config writes are
// taken throughout.
// Config: cfg_we with cfg_index 0 rows, 1 columns, 2 hole limit; write only
// while idle.
module largest_square_few_holes_finder_top #(
  parameter int MAX_DIM = lsq_pkg::MAX_DIM_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_req_type,
  input  logic [7:0] in_hole_row,
  input  logic [7:0] in_hole_col,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output logic       out_valid,
  output logic [7:0] out_bottom_x,
  output logic [7:0] out_bottom_y,
  output logic [7:0] out_top_x,
  output logic [7:0] out_top_y,
  output logic [7:0] out_square_side,
  output logic [3:0] out_holes_inside
);
  logic [7:0] rows_r, cols_r;
  logic [3:0] limit_r;

  // configuration registers; unknown index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= 8'd128;
      cols_r  <= 8'd128;
      limit_r <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        lsq_pkg::CFG_ROWS:  rows_r  <= cfg_data;
        lsq_pkg::CFG_COLS:  cols_r  <= cfg_data;
        lsq_pkg::CFG_LIMIT: limit_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  lsq_pkg::cmd_t  cmd;
  lsq_pkg::stat_t stat;
  logic           ctrl_busy, accept;

  assign busy   = ctrl_busy || !stat.clr_done;
  assign accept = start && !busy;

  lsq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .solve_req (accept && in_req_type),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (ctrl_busy)
  );

  lsq_dpath #(.MAX_DIM(MAX_DIM)) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .hole_we          (accept && !in_req_type),
    .hole_row         (in_hole_row),
    .hole_col         (in_hole_col),
    .row_count        (rows_r),
    .col_count        (cols_r),
    .hole_limit       (limit_r),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_bottom_x     (out_bottom_x),
    .out_bottom_y     (out_bottom_y),
    .out_top_x        (out_top_x),
    .out_top_y        (out_top_y),
    .out_square_side  (out_square_side),
    .out_holes_inside (out_holes_inside)
  );

  // a result only follows while the block is busy
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside a solve");
  // result never repeats back to back
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result repeated");
  // an empty result carries no holes
  a_side_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_square_side == 8'd0) |-> (out_holes_inside == 4'd0))
    else $error("empty result carries holes");
endmodule

FILE: dv/tb.sv
// Self-checking testbench for largest_square_few_holes_finder_top.
// Holds its own grid model and checks every solve word; needs only lsq_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          GRID_MAX   = 128;
  localparam int          RAND_WORDS = 400;
  // worst solve on a full grid: build, every probe, rescan and clear sweep
  localparam int          SOLVE_CYC  = 600_000;
  localparam int          LIMIT_CYC  = 4 * (RAND_WORDS + 64) * SOLVE_CYC;
  localparam logic [1:0]  CFG_NONE   = 2'd3;   // unmapped register index
  localparam bit          REQ_HOLE   = 1'b0;
  localparam bit          REQ_SOLVE  = 1'b1;

  typedef struct packed {
    logic [7:0] bx;
    logic [7:0] by;
    logic [7:0] tx;
    logic [7:0] ty;
    logic [7:0] side;
    logic [3:0] holes;
  } square_t;

  // One directed row: either a register write or a word, with an optional
  // expectation typed in by hand.
  typedef struct {
    bit         is_cfg;
    logic [1:0] idx;
    logic [7:0] data;
    bit         req;
    logic [7:0] row;
    logic [7:0] col;
    bit         fixed;
    square_t    sq;
  } step_t;

  logic       clk, rst_n, start, busy;
  logic       in_req_type;
  logic [7:0] in_hole_row, in_hole_col;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic       out_valid;
  logic [7:0] out_bottom_x, out_bottom_y, out_top_x, out_top_y, out_square_side;
  logic [3:0] out_holes_inside;

  largest_square_few_holes_finder_top u_top (
    .clk, .rst_n, .start, .busy, .in_req_type, .in_hole_row, .in_hole_col,
    .cfg_we, .cfg_index, .cfg_data, .out_valid, .out_bottom_x, .out_bottom_y,
    .out_top_x, .out_top_y, .out_square_side, .out_holes_inside
  );

  // Grid model, its registers, and the squares still owed by the block.
  bit         hole_grid [1:GRID_MAX][1:GRID_MAX];
  int         psum      [0:GRID_MAX][0:GRID_MAX];
  logic [7:0] rows_reg, cols_reg;
  logic [3:0] limit_reg;
  square_t    pending_squares[$];
  int         errors, cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung block must still end the run with a verdict.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYC) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Fewest holes over all s x s windows, first such window in row-major order.
  function automatic int scan_side(int rows, int cols, int s, output int br, output int bc);
    int best, h;
    best = 32'h7fff_ffff;
    br = 0;
    bc = 0;
    for (int r = 0; r + s <= rows; r++)
      for (int c = 0; c + s <= cols; c++) begin
        h = psum[r+s][c+s] - psum[r+s][c] - psum[r][c+s] + psum[r][c];
        if (h < best) begin
          best = h;
          br = r;
          bc = c;
        end
      end
    return best;
  endfunction

  // Build the prefix table, binary-search the side, rescan the winning side, then wipe the grid.
  function automatic square_t solve_grid();
    int rows, cols, lo, hi, mid, side, br, bc, h;
    square_t sq;
    rows = (rows_reg > GRID_MAX) ? GRID_MAX : rows_reg;
    cols = (cols_reg > GRID_MAX) ? GRID_MAX : cols_reg;
    for (int r = 0; r <= rows; r++)
      for (int c = 0; c <= cols; c++)
        psum[r][c] = (r == 0 || c == 0) ? 0 :
                     psum[r-1][c] + psum[r][c-1] - psum[r-1][c-1] + hole_grid[r][c];
    side = 0;
    lo = 1;
    hi = (rows < cols) ? rows : cols;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (scan_side(rows, cols, mid, br, bc) <= limit_reg) begin
        side = mid;
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    sq = '0;
    if (side != 0) begin
      h = scan_side(rows, cols, side, br, bc);
      sq.bx    = 8'(br + side);
      sq.by    = 8'(bc + 1);
      sq.tx    = 8'(br + 1);
      sq.ty    = 8'(bc + side);
      sq.side  = 8'(side);
      sq.holes = 4'(h);
    end
    foreach (hole_grid[r, c]) hole_grid[r][c] = 1'b0;
    return sq;
  endfunction

  // Present one word at the falling edge and hold it until accepted; start
  // stays high so a following word can go back to back.
  task automatic send_word(bit req, logic [7:0] row, logic [7:0] col,
                           bit fixed = 1'b0, square_t sq = '0);
    square_t want;
    @(negedge clk);
    start       <= 1'b1;
    in_req_type <= req;
    in_hole_row <= row;
    in_hole_col <= col;
    do @(posedge clk); while (busy);
    if (req == REQ_HOLE) begin
      if (row >= 1 && row <= GRID_MAX && col >= 1 && col <= GRID_MAX)
        hole_grid[row][col] = 1'b1;
    end else begin
      want = solve_grid();
      pending_squares.push_back(fixed ? sq : want);
    end
  endtask

  // Drop start and keep it low while the task waits.
  task automatic hold_off(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Drop start and wait until nothing is owed and the block is idle, then
  // wait out the extra margin for any hole word still in flight.
  task automatic drain(int extra = 4);
    hold_off(1);
    do @(posedge clk); while (busy || pending_squares.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      lsq_pkg::CFG_ROWS:  rows_reg  = data;
      lsq_pkg::CFG_COLS:  cols_reg  = data;
      lsq_pkg::CFG_LIMIT: limit_reg = data[3:0];
      default: ;
    endcase
  endtask

  // Compare each result word with the oldest owed square.
  always @(posedge clk) begin
    square_t want;
    if (rst_n && out_valid) begin
      if (pending_squares.size() == 0) begin
        report_mismatch("unexpected result words", 1, 0);
      end else begin
        want = pending_squares.pop_front();
        if (out_bottom_x != want.bx)        report_mismatch("bottom_x", out_bottom_x, want.bx);
        if (out_bottom_y != want.by)        report_mismatch("bottom_y", out_bottom_y, want.by);
        if (out_top_x != want.tx)           report_mismatch("top_x", out_top_x, want.tx);
        if (out_top_y != want.ty)           report_mismatch("top_y", out_top_y, want.ty);
        if (out_square_side != want.side)   report_mismatch("square_side", out_square_side,
                                                            want.side);
        if (out_holes_inside != want.holes) report_mismatch("holes_inside", out_holes_inside,
                                                            want.holes);
      end
    end
  end

  function automatic step_t cfg_step(logic [1:0] idx, logic [7:0] data);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.idx    = idx;
    s.data   = data;
    return s;
  endfunction

  function automatic step_t word_step(bit req, logic [7:0] row, logic [7:0] col,
                                      bit fixed = 1'b0, square_t sq = '0);
    step_t s;
    s = '{default: '0};
    s.req   = req;
    s.row   = row;
    s.col   = col;
    s.fixed = fixed;
    s.sq    = sq;
    return s;
  endfunction

  // Pick a grid size: mostly small, now and then mid-sized, zero or oversized.
  function automatic logic [7:0] pick_size();
    case ($urandom_range(0, 19))
      0:       return 8'd0;
      1:       return 8'($urandom_range(129, 255));
      2, 3:    return 8'($urandom_range(17, 40));
      default: return 8'($urandom_range(1, 16));
    endcase
  endfunction

  initial begin
    step_t      plan[$];
    int         sent, phase, words, burst_left, eff_r, eff_c;
    bit         bursty;
    logic [7:0] r, c;

    errors      = 0;
    cycles      = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_req_type = 1'b0;
    in_hole_row = '0;
    in_hole_col = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    rows_reg    = 8'd128;
    cols_reg    = 8'd128;
    limit_reg   = 4'd1;
    foreach (hole_grid[i, j]) hole_grid[i][j] = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. An empty full grid after reset: the whole grid is the square.
    plan.push_back(word_step(REQ_SOLVE, 8'd0, 8'd0, 1'b1,
                             '{8'd128, 8'd1, 8'd1, 8'd128, 8'd128, 4'd0}));
    // Corner hole plus out-of-range holes that must be dropped.
    plan.push_back(word_step(REQ_HOLE, 8'd128, 8'd128));
    plan.push_back(word_step(REQ_HOLE, 8'd0, 8'd5));
    plan.push_back(word_step(REQ_HOLE, 8'd129, 8'd3));
    plan.push_back(word_step(REQ_HOLE, 8'd255, 8'd255));
    plan.push_back(cfg_step(lsq_pkg::CFG_LIMIT, 8'd0));
    plan.push_back(word_step(REQ_SOLVE, 8'd255, 8'd255));
    // Oversized size registers saturate; a repeated hole counts once.
    plan.push_back(cfg_step(lsq_pkg::CFG_ROWS, 8'd255));
    plan.push_back(cfg_step(lsq_pkg::CFG_COLS, 8'd200));
    plan.push_back(word_step(REQ_HOLE, 8'd1, 8'd1));
    plan.push_back(word_step(REQ_HOLE, 8'd1, 8'd1));
    plan.push_back(word_step(REQ_SOLVE, 8'd0, 8'd0));
    // Zero rows: no square at all.
    plan.push_back(cfg_step(lsq_pkg::CFG_ROWS, 8'd0));
    plan.push_back(word_step(REQ_HOLE, 8'd2, 8'd2));
    plan.push_back(word_step(REQ_SOLVE, 8'd0, 8'd0, 1'b1, '0));
    // Single cell with its only cell a hole and no holes allowed.
    plan.push_back(cfg_step(lsq_pkg::CFG_ROWS, 8'd1));
    plan.push_back(cfg_step(lsq_pkg::CFG_COLS, 8'd1));
    plan.push_back(word_step(REQ_HOLE, 8'd1, 8'd1));
    plan.push_back(word_step(REQ_SOLVE, 8'd0, 8'd0, 1'b1, '0));
    // Unmapped index is ignored; upper data bits of the limit are dropped.
    plan.push_back(cfg_step(CFG_NONE, 8'd7));
    plan.push_back(cfg_step(lsq_pkg::CFG_LIMIT, 8'hF3));
    plan.push_back(cfg_step(lsq_pkg::CFG_ROWS, 8'd3));
    plan.push_back(word_step(REQ_HOLE, 8'd2, 8'd1));
    plan.push_back(word_step(REQ_SOLVE, 8'd0, 8'd0));
    plan.push_back(cfg_step(lsq_pkg::CFG_LIMIT, 8'd15));
    plan.push_back(word_step(REQ_SOLVE, 8'd0, 8'd0));

    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        drain();
        write_reg(plan[k].idx, plan[k].data);
      end else begin
        send_word(plan[k].req, plan[k].row, plan[k].col, plan[k].fixed, plan[k].sq);
      end
    end

    // Random part: each phase sets a fresh size and limit, fills holes
    // mostly inside the grid, then solves.
    sent  = 0;
    phase = 0;
    while (sent < RAND_WORDS) begin
      drain();
      write_reg(lsq_pkg::CFG_ROWS, pick_size());
      write_reg(lsq_pkg::CFG_COLS, pick_size());
      write_reg(lsq_pkg::CFG_LIMIT, 8'($urandom_range(0, 15)));
      eff_r      = (rows_reg == 0) ? 1 : ((rows_reg > GRID_MAX) ? GRID_MAX : rows_reg);
      eff_c      = (cols_reg == 0) ? 1 : ((cols_reg > GRID_MAX) ? GRID_MAX : cols_reg);
      words      = $urandom_range(3, 30);
      bursty     = ($urandom_range(0, 3) != 0);
      burst_left = $urandom_range(1, 12);
      for (int w = 0; w < words; w++) begin
        // Gap between bursts; some phases stream with no gaps at all.
        if (bursty && burst_left == 0) begin
          hold_off($urandom_range(1, 6));
          burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        if ($urandom_range(0, 15) == 0) begin
          r = 8'($urandom_range(0, 255));
          c = 8'($urandom_range(0, 255));
        end else begin
          r = 8'($urandom_range(1, eff_r));
          c = 8'($urandom_range(1, eff_c));
        end
        // Occasional stray solve mid-phase breaks up the hole sequence.
        send_word(($urandom_range(0, 24) == 0) ? REQ_SOLVE : REQ_HOLE, r, c);
        sent++;
      end
      // Once, pause until every owed result has come before the solve.
      if (phase == 1) drain();
      send_word(REQ_SOLVE, 8'($urandom), 8'($urandom));
      sent++;
      phase++;
    end

    drain(20);
    if (pending_squares.size() != 0) begin
      $display("%0d results never arrived", pending_squares.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
